// ===== rtl/core/xmld_pkg.sv =====
`default_nettype none

package xmld_pkg;

  // One character of text.
  typedef logic [7:0] char_t;

  // Longest burst that one input beat can cause: an ampersand, four held
  // name characters and one more character.
  localparam int unsigned BurstDepth = 6;
  localparam int unsigned CountWidth = $clog2(BurstDepth + 1);

  typedef logic [CountWidth-1:0] count_t;

  localparam char_t CH_AMP   = 8'h26;  // &
  localparam char_t CH_SEMI  = 8'h3B;  // ;
  localparam char_t CH_LT    = 8'h3C;  // <
  localparam char_t CH_GT    = 8'h3E;  // >
  localparam char_t CH_APOS  = 8'h27;  // '
  localparam char_t CH_QUOT  = 8'h22;  // "
  localparam char_t CH_NONE  = 8'h00;

  localparam char_t CH_L = 8'h6C;
  localparam char_t CH_T = 8'h74;
  localparam char_t CH_G = 8'h67;
  localparam char_t CH_A = 8'h61;
  localparam char_t CH_M = 8'h6D;
  localparam char_t CH_P = 8'h70;
  localparam char_t CH_O = 8'h6F;
  localparam char_t CH_S = 8'h73;
  localparam char_t CH_Q = 8'h71;
  localparam char_t CH_U = 8'h75;

  // Partial match after an ampersand. The P_ states name the characters held.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_AMP    = 4'd1,
    ST_P_L    = 4'd2,
    ST_P_LT   = 4'd3,
    ST_P_G    = 4'd4,
    ST_P_GT   = 4'd5,
    ST_P_A    = 4'd6,
    ST_P_AM   = 4'd7,
    ST_P_AMP  = 4'd8,
    ST_P_AP   = 4'd9,
    ST_P_APO  = 4'd10,
    ST_P_APOS = 4'd11,
    ST_P_Q    = 4'd12,
    ST_P_QU   = 4'd13,
    ST_P_QUO  = 4'd14,
    ST_P_QUOT = 4'd15
  } match_state_t;

  typedef struct packed {
    char_t in_byte;
    logic  in_last;
  } in_beat_t;

  typedef struct packed {
    char_t out_byte;
    logic  out_last;
  } out_beat_t;

  // Characters produced by one input beat, oldest in entry 0.
  typedef struct packed {
    logic [BurstDepth-1:0][7:0] chars;
    count_t                     count;
    logic                       last;
  } burst_t;

  // State reached when character c extends the name; ST_IDLE when it does not.
  function automatic match_state_t step_state(match_state_t s, char_t c);
    match_state_t r;
    r = ST_IDLE;
    case (s)
      ST_AMP: begin
        if (c == CH_L) r = ST_P_L;
        else if (c == CH_G) r = ST_P_G;
        else if (c == CH_A) r = ST_P_A;
        else if (c == CH_Q) r = ST_P_Q;
      end
      ST_P_L:   if (c == CH_T) r = ST_P_LT;
      ST_P_G:   if (c == CH_T) r = ST_P_GT;
      ST_P_A: begin
        if (c == CH_M) r = ST_P_AM;
        else if (c == CH_P) r = ST_P_AP;
      end
      ST_P_AM:  if (c == CH_P) r = ST_P_AMP;
      ST_P_AP:  if (c == CH_O) r = ST_P_APO;
      ST_P_APO: if (c == CH_S) r = ST_P_APOS;
      ST_P_Q:   if (c == CH_U) r = ST_P_QU;
      ST_P_QU:  if (c == CH_O) r = ST_P_QUO;
      ST_P_QUO: if (c == CH_T) r = ST_P_QUOT;
      default:  r = ST_IDLE;
    endcase
    return r;
  endfunction

  // Replacement character when a semicolon closes the name; CH_NONE if none.
  function automatic char_t done_char(match_state_t s);
    char_t r;
    case (s)
      ST_P_LT:   r = CH_LT;
      ST_P_GT:   r = CH_GT;
      ST_P_AMP:  r = CH_AMP;
      ST_P_APOS: r = CH_APOS;
      ST_P_QUOT: r = CH_QUOT;
      default:   r = CH_NONE;
    endcase
    return r;
  endfunction

  // Number of characters a literal flush emits: the ampersand plus the name.
  function automatic count_t flush_len(match_state_t s);
    count_t r;
    case (s)
      ST_IDLE:                                    r = count_t'(0);
      ST_AMP:                                     r = count_t'(1);
      ST_P_L, ST_P_G, ST_P_A, ST_P_Q:             r = count_t'(2);
      ST_P_LT, ST_P_GT, ST_P_AM, ST_P_AP, ST_P_QU: r = count_t'(3);
      ST_P_AMP, ST_P_APO, ST_P_QUO:               r = count_t'(4);
      ST_P_APOS, ST_P_QUOT:                       r = count_t'(5);
      default:                                    r = count_t'(0);
    endcase
    return r;
  endfunction

  // Character at position i of a literal flush; position 0 is the ampersand.
  function automatic char_t flush_char(match_state_t s, count_t i);
    logic [3:0][7:0] name;
    char_t           r;
    case (s)
      ST_P_L:    name = {CH_NONE, CH_NONE, CH_NONE, CH_L};
      ST_P_LT:   name = {CH_NONE, CH_NONE, CH_T, CH_L};
      ST_P_G:    name = {CH_NONE, CH_NONE, CH_NONE, CH_G};
      ST_P_GT:   name = {CH_NONE, CH_NONE, CH_T, CH_G};
      ST_P_A:    name = {CH_NONE, CH_NONE, CH_NONE, CH_A};
      ST_P_AM:   name = {CH_NONE, CH_NONE, CH_M, CH_A};
      ST_P_AMP:  name = {CH_NONE, CH_P, CH_M, CH_A};
      ST_P_AP:   name = {CH_NONE, CH_NONE, CH_P, CH_A};
      ST_P_APO:  name = {CH_NONE, CH_O, CH_P, CH_A};
      ST_P_APOS: name = {CH_S, CH_O, CH_P, CH_A};
      ST_P_Q:    name = {CH_NONE, CH_NONE, CH_NONE, CH_Q};
      ST_P_QU:   name = {CH_NONE, CH_NONE, CH_U, CH_Q};
      ST_P_QUO:  name = {CH_NONE, CH_O, CH_U, CH_Q};
      ST_P_QUOT: name = {CH_T, CH_O, CH_U, CH_Q};
      default:   name = '0;
    endcase
    case (i)
      count_t'(0): r = CH_AMP;
      count_t'(1): r = name[0];
      count_t'(2): r = name[1];
      count_t'(3): r = name[2];
      count_t'(4): r = name[3];
      default:     r = CH_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xml_entity_decoder_top.sv =====
`default_nettype none

// Channel  Direction  Handshake              Beat
// in       input      in_valid / in_ready    in_data  (in_byte, in_last)
// out      output     out_valid / out_ready  out_data (out_byte, out_last)
//
// Each input beat is decoded in the cycle it is accepted and its characters
// are loaded into a burst register of up to six entries.
// A beat that yields zero or one character keeps in_ready high while out_ready
// is high, so ordinary text flows at one beat per clock; a longer burst holds
// in_ready low as it drains, one character a cycle while out_ready is high.
// Reset is synchronous on rst and leaves no entity pending and the burst empty.
// A stall on out_ready holds the current character and, once the burst is
// down to its last entry, also holds off the next input beat.

module xml_entity_decoder_top import xmld_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_beat_t     out_data
);

  // A beat is taken whenever the burst register will be free at this edge.
  logic   accept;
  burst_t burst;

  assign accept = in_valid && in_ready;

  // Entity matcher: holds the partial name after an ampersand and works out
  // every character that the current beat releases.
  xmld_match u_match (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .beat  (in_data),
    .burst (burst)
  );

  // Burst register: presents the released characters one per beat and marks
  // the final character of a string.
  xmld_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .burst     (burst),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/xmld_match.sv =====
`default_nettype none

module xmld_match import xmld_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire in_beat_t beat,
  output burst_t        burst
);

  match_state_t state;
  match_state_t state_next;

  match_state_t edge_to;
  char_t        repl_char;
  logic         repl;
  logic         extend;
  logic         mismatch;

  match_state_t flush_state;
  count_t       flush_count;
  char_t        tail_char;
  logic         tail_valid;

  always_comb begin
    edge_to   = step_state(state, beat.in_byte);
    repl_char = done_char(state);
    repl      = (state != ST_IDLE) && (beat.in_byte == CH_SEMI) && (repl_char != CH_NONE);
    extend    = (state != ST_IDLE) && !repl && (edge_to != ST_IDLE);
    mismatch  = (state != ST_IDLE) && !repl && !extend;
  end

  // Next state.
  always_comb begin
    if (beat.in_last || repl) begin
      state_next = ST_IDLE;
    end else if (extend) begin
      state_next = edge_to;
    end else if (beat.in_byte == CH_AMP) begin
      state_next = ST_AMP;
    end else begin
      state_next = ST_IDLE;
    end
  end

  // Burst: a literal flush of some state, then at most one more character.
  always_comb begin
    if (repl) begin
      flush_state = ST_IDLE;
      tail_char   = repl_char;
      tail_valid  = 1'b1;
    end else if (extend) begin
      flush_state = beat.in_last ? edge_to : ST_IDLE;
      tail_char   = beat.in_byte;
      tail_valid  = 1'b0;
    end else begin
      flush_state = mismatch ? state : ST_IDLE;
      tail_char   = beat.in_byte;
      // A fresh ampersand is held, unless the string ends here.
      tail_valid  = (beat.in_byte != CH_AMP) || beat.in_last;
    end
    flush_count = flush_len(flush_state);
    for (int i = 0; i < BurstDepth; i++) begin
      if (count_t'(i) < flush_count) begin
        burst.chars[i] = flush_char(flush_state, count_t'(i));
      end else begin
        burst.chars[i] = tail_char;
      end
    end
    burst.count = flush_count + count_t'(tail_valid);
    burst.last  = beat.in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (load) begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    load && beat.in_last |=> state == ST_IDLE)
    else $error("match state not cleared after end of string");

  a_repl_single: assert property (@(posedge clk) disable iff (rst)
    repl |-> burst.count == count_t'(1))
    else $error("entity replacement must give one character");

  a_last_nonempty: assert property (@(posedge clk) disable iff (rst)
    beat.in_last |-> burst.count != count_t'(0))
    else $error("end of string gave no character");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/xmld_burst.sv =====
`default_nettype none

module xmld_burst import xmld_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire burst_t burst,
  output logic        ready,
  output logic        out_valid,
  input  wire logic   out_ready,
  output out_beat_t   out_data
);

  logic [BurstDepth-1:0][7:0] chars;
  count_t                     count;
  logic                       last;
  logic                       take;

  assign out_valid         = (count != count_t'(0));
  assign take              = out_valid && out_ready;
  assign ready             = (count == count_t'(0)) || ((count == count_t'(1)) && out_ready);
  assign out_data.out_byte = chars[0];
  assign out_data.out_last = last && (count == count_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.count;
    end else if (take) begin
      count <= count - count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= burst.chars;
      last  <= burst.last;
    end else if (take) begin
      for (int i = 0; i < BurstDepth - 1; i++) begin
        chars[i] <= chars[i+1];
      end
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(BurstDepth))
    else $error("burst count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> count <= count_t'(1))
    else $error("burst loaded over pending characters");

  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    take && !load |=> count == $past(count) - count_t'(1))
    else $error("burst did not advance by one character");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_xml_entity_decoder_top.sv =====
`timescale 1ns / 1ps

// Testbench for the XML predefined entity decoder.
//
// Input beats are driven on the falling clock edge. Both handshakes are sampled
// on the rising edge by one monitor process. That process first feeds each
// accepted input beat to the decoder model below and queues the characters it
// predicts. It then compares each accepted output beat with the oldest queued
// character.
module tb_xml_entity_decoder_top;
  import xmld_pkg::*;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  // Random idling on both channels is allowed only while this is set.
  bit idling = 1'b0;

  int unsigned beats_in      = 0;
  int unsigned beats_out     = 0;
  int unsigned entities_seen = 0;
  int unsigned errors        = 0;

  // The five names that the decoder recognizes, with their replacements.
  string entity_names [5] = '{"lt", "gt", "amp", "apos", "quot"};
  char_t entity_chars [5] = '{CH_LT, CH_GT, CH_AMP, CH_APOS, CH_QUOT};

  // Decoder model state. An ampersand opens a reference, and the name
  // characters that follow it are held until the reference closes or breaks.
  bit    entity_open = 1'b0;
  char_t name_held [$];

  // Characters that one input beat produces, and all output beats still due.
  char_t     burst_q [$];
  out_beat_t expected_q [$];

  xml_entity_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // A character continues the open reference only when the held name followed
  // by that character is still a prefix of one of the five names.
  function automatic bit name_continues(char_t c);
    int  k;
    int  i;
    bit  ok;
    for (k = 0; k < 5; k++) begin
      if (name_held.size() < entity_names[k].len()) begin
        ok = (char_t'(entity_names[k].getc(name_held.size())) == c);
        for (i = 0; i < name_held.size(); i++) begin
          if (char_t'(entity_names[k].getc(i)) != name_held[i]) ok = 1'b0;
        end
        if (ok) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Returns the index of the name that the held characters spell in full,
  // or -1 when they spell none.
  function automatic int complete_name();
    int k;
    int i;
    bit ok;
    for (k = 0; k < 5; k++) begin
      if (name_held.size() == entity_names[k].len()) begin
        ok = 1'b1;
        for (i = 0; i < name_held.size(); i++) begin
          if (char_t'(entity_names[k].getc(i)) != name_held[i]) ok = 1'b0;
        end
        if (ok) return k;
      end
    end
    return -1;
  endfunction

  // A broken or unfinished reference comes out literally: the ampersand and
  // then every held name character.
  function automatic void spill_reference();
    if (entity_open) begin
      burst_q.push_back(CH_AMP);
      foreach (name_held[i]) burst_q.push_back(name_held[i]);
    end
    entity_open = 1'b0;
    name_held.delete();
  endfunction

  // Works out the output beats of one accepted input beat and queues them.
  function automatic void decode_beat(in_beat_t b);
    int        k;
    bit        consumed;
    out_beat_t e;
    burst_q.delete();
    consumed = 1'b0;
    if (entity_open) begin
      k = complete_name();
      if (b.in_byte == CH_SEMI && k >= 0) begin
        burst_q.push_back(entity_chars[k]);
        entity_open = 1'b0;
        name_held.delete();
        entities_seen++;
        consumed = 1'b1;
      end else if (name_continues(b.in_byte)) begin
        name_held.push_back(b.in_byte);
        consumed = 1'b1;
      end else begin
        spill_reference();
      end
    end
    // A character that broke the reference is then handled on its own, so a
    // new ampersand opens a fresh reference at once.
    if (!consumed) begin
      if (b.in_byte == CH_AMP) begin
        entity_open = 1'b1;
      end else begin
        burst_q.push_back(b.in_byte);
      end
    end
    if (b.in_last) spill_reference();
    foreach (burst_q[i]) begin
      e.out_byte = burst_q[i];
      e.out_last = b.in_last && (i == burst_q.size() - 1);
      expected_q.push_back(e);
    end
  endfunction

  // The model is updated before the output check within the same edge, and a
  // character can never leave the block in the edge that accepts its source.
  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        beats_in++;
        decode_beat(in_data);
      end
      if (out_valid && out_ready) begin
        beats_out++;
        if (expected_q.size() == 0) begin
          $error("output beat with nothing expected: out_byte %h out_last %b",
                 out_data.out_byte, out_data.out_last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, out_data.out_byte);
            errors++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last expected %b actual %b", want.out_last, out_data.out_last);
            errors++;
          end
        end
      end
    end
  end

  // The output side stalls for random stretches while idling is on.
  // Each branch assigns out_ready only once per falling edge.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Sends one input beat. An optional gap with valid low comes first. Valid
  // then holds with steady data until the beat is taken at a rising edge.
  task automatic send_beat(char_t c, logic last);
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: c, in_last: last};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(string s, bit last_at_end);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_beat(char_t'(s.getc(i)), last_at_end && (i == s.len() - 1));
    end
  endtask

  // Four of the five references are sent whole. The string closes on the
  // final semicolon, so the replacement itself carries out_last.
  task automatic test_entities();
    send_text("&gt;", 1'b0);
    send_text("&amp;", 1'b0);
    send_text("&apos;", 1'b0);
    send_text("&quot;", 1'b1);
  endtask

  task automatic test_special_cases();
    // An ampersand in the middle of a name spills the old prefix and opens
    // the less-than reference.
    send_text("&ap&lt;", 1'b0);
    // A zero byte and an all-ones byte pass through, and the second ends a
    // string with nothing held.
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    // A semicolon straight after the ampersand closes nothing.
    send_text("&;", 1'b0);
    // A full name broken by a stray letter on the last byte gives the
    // longest burst: six characters, with out_last on the stray letter.
    send_text("&quotx", 1'b1);
  endtask

  // A character that is likely to break an open reference in an interesting
  // way: a lowercase letter, a semicolon, an ampersand or any byte at all.
  function automatic char_t stray_char();
    char_t c;
    case ($urandom_range(0, 3))
      0:       c = char_t'($urandom_range(8'h61, 8'h7A));
      1:       c = CH_SEMI;
      2:       c = CH_AMP;
      default: c = char_t'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // Random text made of tokens. Most tokens are whole references or broken
  // ones, so every prefix state is reached often. The rest are plain bytes
  // and stray ampersands or semicolons. Strings end at random points, in the
  // middle of a name too.
  task automatic test_random(int unsigned n_items, bit allow_idle);
    int unsigned sent;
    int          k;
    int          cut;
    int          i;
    bit          end_str;
    char_t       tok [$];
    idling = allow_idle;
    sent   = 0;
    while (sent < n_items) begin
      tok.delete();
      k = $urandom_range(0, 4);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          tok.push_back(CH_AMP);
          for (i = 0; i < entity_names[k].len(); i++) begin
            tok.push_back(char_t'(entity_names[k].getc(i)));
          end
          tok.push_back(CH_SEMI);
        end
        4, 5: begin
          cut = $urandom_range(0, entity_names[k].len());
          tok.push_back(CH_AMP);
          for (i = 0; i < cut; i++) tok.push_back(char_t'(entity_names[k].getc(i)));
          tok.push_back(stray_char());
        end
        6, 7, 8: begin
          repeat ($urandom_range(1, 4)) tok.push_back(char_t'($urandom_range(0, 255)));
        end
        default: begin
          tok.push_back($urandom_range(0, 1) ? CH_AMP : CH_SEMI);
        end
      endcase
      end_str = ($urandom_range(0, 4) == 0);
      for (i = 0; i < tok.size(); i++) begin
        send_beat(tok[i], (i == tok.size() - 1) ? end_str : ($urandom_range(0, 19) == 0));
      end
      sent += tok.size();
    end
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_entities();
    test_special_cases();
    test_random(230, 1'b1);
    // The closing stretch runs at full rate on both sides.
    test_random(60, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Decoded %0d input beats into %0d checked output beats, including %0d entity",
             beats_in, beats_out, entities_seen);
    $display("references, broken prefixes, stray ampersands and strings ending mid-name.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // This watchdog gives the slowest correct run a wide margin before giving
  // up.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== xml_entity_decoder_top.f =====
rtl/core/xmld_pkg.sv
rtl/core/xmld_match.sv
rtl/core/xmld_burst.sv
rtl/core/xml_entity_decoder_top.sv
tb/tb_xml_entity_decoder_top.sv
